@@ rtl/deq_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the double-ended queue
// no dependencies; used by the interfaces and every module

package deq_pkg;

	localparam int OP_W            = 3;
	localparam int DATA_W          = 32;
	localparam int POS_W           = 12;
	localparam int COUNT_W         = 12;
	localparam int STATUS_W        = 2;
	localparam int CAPACITY_DEF    = 2048;
	localparam int WORD_BITS_DEF   = 32;
	localparam int CMD_QUEUE_DEPTH = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_READ       = 3'd4,
		OP_RESIZE     = 3'd5,
		OP_CLEAR      = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		CMD_PUSH_BACK,
		CMD_PUSH_FRONT,
		CMD_POP_BACK,
		CMD_POP_FRONT,
		CMD_READ,
		CMD_RESIZE,
		CMD_CLEAR,
		CMD_NOP
	} cmd_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [DATA_W-1:0] word;
		logic [POS_W-1:0]  pos;
		logic              pos_over;
	} cmd_t;

endpackage

@@ rtl/deq_req_if.sv @@
`timescale 1ns / 1ps
// request channel of the double-ended queue: valid/ready plus one operation word
// depends on deq_pkg

interface deq_req_if;
	logic                              valid;
	logic                              ready;
	logic [deq_pkg::OP_W-1:0]          operation;
	logic signed [deq_pkg::DATA_W-1:0] value;
	logic [deq_pkg::POS_W-1:0]         position;

	modport source (output valid, output operation, output value, output position,
		input ready);
	modport sink (input valid, input operation, input value, input position,
		output ready);
endinterface

@@ rtl/deq_rsp_if.sv @@
`timescale 1ns / 1ps
// response channel of the double-ended queue: valid/ready plus one result word
// depends on deq_pkg

interface deq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [deq_pkg::DATA_W-1:0] read_value;
	logic signed [deq_pkg::DATA_W-1:0] front_value;
	logic signed [deq_pkg::DATA_W-1:0] back_value;
	logic [deq_pkg::COUNT_W-1:0]       element_count;
	logic                              is_empty;
	logic [deq_pkg::STATUS_W-1:0]      status;

	modport source (output valid, output read_value, output front_value,
		output back_value, output element_count, output is_empty, output status,
		input ready);
	modport sink (input valid, input read_value, input front_value,
		input back_value, input element_count, input is_empty, input status,
		output ready);
endinterface

@@ rtl/deq_front.sv @@
`timescale 1ns / 1ps
// front end: accepts request words, decodes them into commands and buffers
// them in a short command queue; depends on deq_pkg and deq_req_if

module deq_front #(
	parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	deq_req_if.sink       req,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output deq_pkg::cmd_t cmd
);

	localparam int DEPTH = deq_pkg::CMD_QUEUE_DEPTH;
	localparam int QP_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int QC_W  = $clog2(DEPTH + 1);

	deq_pkg::cmd_t    decoded;
	deq_pkg::cmd_t    queue_q [DEPTH];
	logic [QP_W-1:0]  wr_ptr_q;
	logic [QP_W-1:0]  rd_ptr_q;
	logic [QC_W-1:0]  fill_q;
	logic             push;
	logic             pop;

	function automatic logic [QP_W-1:0] next_ptr(input logic [QP_W-1:0] p);
		return (p == QP_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		decoded.word = req.value;
		decoded.pos  = req.position;
		// a position above capacity fits neither a resize nor any stored index
		decoded.pos_over = 32'(req.position) > 32'(CAPACITY);
		case (deq_pkg::op_t'(req.operation))
			deq_pkg::OP_PUSH_BACK:  decoded.kind = deq_pkg::CMD_PUSH_BACK;
			deq_pkg::OP_PUSH_FRONT: decoded.kind = deq_pkg::CMD_PUSH_FRONT;
			deq_pkg::OP_POP_BACK:   decoded.kind = deq_pkg::CMD_POP_BACK;
			deq_pkg::OP_POP_FRONT:  decoded.kind = deq_pkg::CMD_POP_FRONT;
			deq_pkg::OP_READ:       decoded.kind = deq_pkg::CMD_READ;
			deq_pkg::OP_RESIZE:     decoded.kind = deq_pkg::CMD_RESIZE;
			deq_pkg::OP_CLEAR:      decoded.kind = deq_pkg::CMD_CLEAR;
			default:                decoded.kind = deq_pkg::CMD_NOP;
		endcase
	end

	assign req.ready = (fill_q != QC_W'(DEPTH));
	assign push      = req.valid && req.ready;
	assign cmd_valid = (fill_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			fill_q <= fill_q + QC_W'(push) - QC_W'(pop);
		end
	end

endmodule

@@ rtl/deq_back.sv @@
`timescale 1ns / 1ps
// back end: executes queued commands against the circular element store and
// registers one result word per command; depends on deq_pkg and deq_rsp_if

module deq_back #(
	parameter int CAPACITY  = deq_pkg::CAPACITY_DEF,
	parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  deq_pkg::cmd_t cmd,
	deq_rsp_if.source     rsp
);

	localparam int PTR_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = CNT_W + 1;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FETCH = 3'b010,
		S_FILL  = 3'b100
	} state_t;

	typedef enum logic [1:0] {
		TGT_FRONT,
		TGT_BACK,
		TGT_READ
	} target_t;

	state_t                 state_q, state_d;
	target_t                tgt_q, tgt_d;
	logic [PTR_W-1:0]       head_q, head_d;
	logic [CNT_W-1:0]       count_q, count_d;
	logic [WORD_BITS-1:0]   front_q, front_d;
	logic [WORD_BITS-1:0]   back_q, back_d;
	logic [WORD_BITS-1:0]   fill_word_q, fill_word_d;
	logic [CNT_W-1:0]       fill_cnt_q, fill_cnt_d;

	logic [WORD_BITS-1:0]   store_mem [CAPACITY];
	logic [WORD_BITS-1:0]   rdata_q;
	logic                   mem_we;
	logic [PTR_W-1:0]       mem_waddr;
	logic [WORD_BITS-1:0]   mem_wdata;
	logic                   mem_re;
	logic [PTR_W-1:0]       mem_raddr;

	logic                   take;
	logic                   out_free;
	logic                   finish;
	deq_pkg::status_t       res_status;
	logic [WORD_BITS-1:0]   res_read;
	logic [WORD_BITS-1:0]   word_in;
	logic [CNT_W-1:0]       pos_c;
	logic                   is_full;
	logic                   is_none;

	logic                   rsp_valid_q;
	logic [deq_pkg::DATA_W-1:0]   rsp_read_q;
	logic [deq_pkg::DATA_W-1:0]   rsp_front_q;
	logic [deq_pkg::DATA_W-1:0]   rsp_back_q;
	logic [deq_pkg::COUNT_W-1:0]  rsp_count_q;
	logic                         rsp_empty_q;
	logic [deq_pkg::STATUS_W-1:0] rsp_status_q;

	// physical slot of an offset from the front; slot plus offset wraps at most once
	function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] base,
		input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(CAPACITY)) begin
			sum = sum - SUM_W'(CAPACITY);
		end
		return PTR_W'(sum);
	endfunction

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign cmd_ready = (state_q == S_IDLE) && out_free;
	assign take      = cmd_valid && cmd_ready;
	assign word_in   = WORD_BITS'(cmd.word);
	assign pos_c     = CNT_W'(cmd.pos);
	assign is_full   = (count_q == CNT_W'(CAPACITY));
	assign is_none   = (count_q == '0);

	always_comb begin
		state_d     = state_q;
		tgt_d       = tgt_q;
		head_d      = head_q;
		count_d     = count_q;
		front_d     = front_q;
		back_d      = back_q;
		fill_word_d = fill_word_q;
		fill_cnt_d  = fill_cnt_q;
		mem_we      = 1'b0;
		mem_waddr   = slot(head_q, count_q);
		mem_wdata   = word_in;
		mem_re      = 1'b0;
		mem_raddr   = head_q;
		finish      = 1'b0;
		res_status  = deq_pkg::ST_OK;
		res_read    = '0;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					case (cmd.kind)
						deq_pkg::CMD_PUSH_BACK: begin
							finish = 1'b1;
							if (is_full) begin
								res_status = deq_pkg::ST_FULL;
							end else begin
								mem_we  = 1'b1;
								count_d = count_q + 1'b1;
								back_d  = word_in;
								if (is_none) begin
									front_d = word_in;
								end
							end
						end
						deq_pkg::CMD_PUSH_FRONT: begin
							finish = 1'b1;
							if (is_full) begin
								res_status = deq_pkg::ST_FULL;
							end else begin
								head_d    = (head_q == '0) ? PTR_W'(CAPACITY - 1)
									: head_q - 1'b1;
								mem_we    = 1'b1;
								mem_waddr = head_d;
								count_d   = count_q + 1'b1;
								front_d   = word_in;
								if (is_none) begin
									back_d = word_in;
								end
							end
						end
						deq_pkg::CMD_POP_BACK: begin
							if (is_none) begin
								finish     = 1'b1;
								res_status = deq_pkg::ST_EMPTY;
							end else begin
								count_d = count_q - 1'b1;
								if (count_d == '0) begin
									finish = 1'b1;
								end else begin
									// new back word comes from the store
									mem_re    = 1'b1;
									mem_raddr = slot(head_q, count_q - CNT_W'(2));
									tgt_d     = TGT_BACK;
									state_d   = S_FETCH;
								end
							end
						end
						deq_pkg::CMD_POP_FRONT: begin
							if (is_none) begin
								finish     = 1'b1;
								res_status = deq_pkg::ST_EMPTY;
							end else begin
								head_d  = (head_q == PTR_W'(CAPACITY - 1)) ? '0
									: head_q + 1'b1;
								count_d = count_q - 1'b1;
								if (count_d == '0) begin
									finish = 1'b1;
								end else begin
									mem_re    = 1'b1;
									mem_raddr = head_d;
									tgt_d     = TGT_FRONT;
									state_d   = S_FETCH;
								end
							end
						end
						deq_pkg::CMD_READ: begin
							if (is_none) begin
								finish     = 1'b1;
								res_status = deq_pkg::ST_EMPTY;
							end else if (cmd.pos_over || pos_c >= count_q) begin
								finish     = 1'b1;
								res_status = deq_pkg::ST_RANGE;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = slot(head_q, pos_c);
								tgt_d     = TGT_READ;
								state_d   = S_FETCH;
							end
						end
						deq_pkg::CMD_RESIZE: begin
							if (cmd.pos_over) begin
								finish     = 1'b1;
								res_status = deq_pkg::ST_FULL;
							end else if (pos_c < count_q) begin
								count_d = pos_c;
								if (pos_c == '0) begin
									finish = 1'b1;
								end else begin
									mem_re    = 1'b1;
									mem_raddr = slot(head_q, pos_c - 1'b1);
									tgt_d     = TGT_BACK;
									state_d   = S_FETCH;
								end
							end else if (pos_c == count_q) begin
								finish = 1'b1;
							end else begin
								fill_word_d = word_in;
								fill_cnt_d  = pos_c;
								state_d     = S_FILL;
							end
						end
						deq_pkg::CMD_CLEAR: begin
							finish  = 1'b1;
							count_d = '0;
							head_d  = '0;
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
			end
			S_FETCH: begin
				finish  = 1'b1;
				state_d = S_IDLE;
				case (tgt_q)
					TGT_FRONT: front_d  = rdata_q;
					TGT_BACK:  back_d   = rdata_q;
					default:   res_read = rdata_q;
				endcase
			end
			S_FILL: begin
				// one appended word a cycle until the target count is reached
				mem_we    = 1'b1;
				mem_wdata = fill_word_q;
				count_d   = count_q + 1'b1;
				back_d    = fill_word_q;
				if (is_none) begin
					front_d = fill_word_q;
				end
				if (count_d == fill_cnt_q) begin
					finish  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= store_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tgt_q       <= TGT_FRONT;
			head_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			tgt_q   <= tgt_d;
			head_q  <= head_d;
			count_q <= count_d;
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		front_q     <= front_d;
		back_q      <= back_d;
		fill_word_q <= fill_word_d;
		fill_cnt_q  <= fill_cnt_d;
		if (finish) begin
			rsp_read_q   <= deq_pkg::DATA_W'(res_read);
			rsp_front_q  <= (count_d == '0) ? '0 : deq_pkg::DATA_W'(front_d);
			rsp_back_q   <= (count_d == '0) ? '0 : deq_pkg::DATA_W'(back_d);
			rsp_count_q  <= deq_pkg::COUNT_W'(count_d);
			rsp_empty_q  <= (count_d == '0);
			rsp_status_q <= res_status;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.read_value    = rsp_read_q;
	assign rsp.front_value   = rsp_front_q;
	assign rsp.back_value    = rsp_back_q;
	assign rsp.element_count = rsp_count_q;
	assign rsp.is_empty      = rsp_empty_q;
	assign rsp.status        = rsp_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= PTR_W'(CAPACITY - 1))
		else $error("head slot outside the store");

	a_fill_below_target: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL |-> count_q < fill_cnt_q)
		else $error("fill running at or past its target count");

	a_fetch_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FETCH |=> state_q == S_IDLE && rsp_valid_q)
		else $error("store fetch did not complete with a result");

endmodule

@@ rtl/double_ended_queue.sv @@
`timescale 1ns / 1ps
// from word to result: command queue, then result register, with a store read register
// between them for index reads and for pops and shrinks that leave elements; a growing
// resize first appends one store word a cycle while filling
// throughput: one word per cycle while results are taken, held during store reads and fills
// reset (asynchronous): queue empty, head slot zero, no results pending; store contents undefined
// depends on deq_pkg, deq_req_if, deq_rsp_if, deq_front and deq_back

module double_ended_queue #(
	parameter int CAPACITY  = deq_pkg::CAPACITY_DEF,
	parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	deq_req_if.sink    req,
	deq_rsp_if.source  rsp
);

	logic          cmd_valid;
	logic          cmd_ready;
	deq_pkg::cmd_t cmd;

	deq_front #(
		.CAPACITY (CAPACITY)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	deq_back #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp       (rsp)
	);

endmodule
